// ===== hw/rtl/alars_pkg.sv =====
`default_nettype none
package alars_pkg;

   localparam int unsigned RAW_W     = 16;
   localparam int unsigned LUX_W     = 32;
   localparam int unsigned XW        = 26;
   localparam int unsigned SUM_W     = 40;
   localparam int unsigned DEN_W     = 14;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;
   localparam int unsigned CNT_Q_W   = 22;
   localparam int unsigned CNT_N_W   = 31;
   localparam int unsigned BASE_W    = 25;
   localparam int unsigned PROD_W    = 63;
   localparam int unsigned RECIP_SH  = 41;

   localparam logic [CSR_IDX_W-1:0] REG_MODE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_QUARTIC = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_CUBIC   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_SQUARE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_LINEAR  = 3'd5;

   localparam logic [1:0] MODE_NORMAL    = 2'd0;
   localparam logic [1:0] MODE_FAST      = 2'd1;
   localparam logic [1:0] MODE_LOW_LIGHT = 2'd2;
   localparam logic [1:0] MODE_NORMAL_B  = 2'd3;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLOSE  = 1'b1;

   localparam logic [1:0] GAIN_EIGHTH  = 2'd0;
   localparam logic [1:0] GAIN_QUARTER = 2'd1;
   localparam logic [1:0] GAIN_UNITY   = 2'd2;
   localparam logic [1:0] GAIN_DOUBLE  = 2'd3;

   localparam logic [LUX_W-1:0] LUX_1000  = 32'd256000;
   localparam logic [LUX_W-1:0] LUX_25    = 32'd6400;
   localparam logic [LUX_W-1:0] LUX_100   = 32'd25600;
   localparam logic [LUX_W-1:0] LUX_10000 = 32'd2560000;

   // Lux Q24.8 = 8q + floor((376q + 312) / 625) with q the count in 0.0336 lux
   // steps; the division by 625 is a multiplication by ceil(2^41 / 625).
   localparam logic [8:0]  LUX_MUL   = 9'd376;
   localparam logic [8:0]  LUX_BIAS  = 9'd312;
   localparam logic [31:0] LUX_RECIP = 32'd3518437209;

   localparam logic signed [63:0] T_LIM = 64'sd68719476735;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_POLY,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [SUM_W-1:0] window_sum;
      logic [LUX_W-1:0] window_min;
      logic [LUX_W-1:0] window_max;
      logic [LUX_W-1:0] display_sum;
      logic [LUX_W-1:0] display_min;
      logic [LUX_W-1:0] display_max;
   } rec_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

   // Every resolution is a power-of-two multiple of 0.0336 lux per count.
   function automatic logic [2:0] lux_shift(input logic [1:0] gain,
                                            input logic low_light);
      logic [2:0] s;
      case (gain)
         GAIN_EIGHTH:  s = 3'd6;
         GAIN_QUARTER: s = 3'd5;
         GAIN_UNITY:   s = 3'd3;
         default:      s = 3'd2;
      endcase
      if (low_light) begin
         s = 3'd0;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/alars_if.sv =====
`default_nettype none
interface alars_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic        channel;
   logic [15:0] raw_count;
   logic        first_sample;
   logic        first_window;
   modport source(output valid, opcode, channel, raw_count, first_sample, first_window,
                  input ready);
   modport sink(input valid, opcode, channel, raw_count, first_sample, first_window,
                output ready);
endinterface

interface alars_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic [1:0]  gain_step;
   logic        gain_changed;
   logic        corrected;
   logic [31:0] min_value;
   logic [31:0] max_value;
   logic [31:0] display_sum;
   modport source(output valid, value, gain_step, gain_changed, corrected, min_value,
                  max_value, display_sum, input ready);
   modport sink(input valid, value, gain_step, gain_changed, corrected, min_value,
                max_value, display_sum, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ambient_light_autorange_stats_core.sv =====
// Ambient light front end with automatic gain ranging and per-channel window
// and display statistics. One item is taken at a time. A raw sample passes
// through a memory read, the lux_n_ff and lux_prod_ff registers that scale
// the count to lux by a reciprocal multiplication, and an update, plus the
// quartic correction when it runs (four Horner steps, each in a low, a high
// and an add phase, and a done register that hands the result over). A window
// close waits on the two-bit-per-cycle divider between its read and update.
// After each result the block returns to idle to take the next transfer, and a
// stalled result channel holds the block in its update state.
// Per-channel statistics live in a small
// synchronous RAM; entries not yet written read as zero through a valid bit
// per channel, so no clearing pass is needed. A result waiting in the output
// register does not block the next transfer on the request side.
`default_nettype none
module ambient_light_autorange_stats_core
   import alars_pkg::*;
#(
   parameter int unsigned CHANNELS = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   alars_req_if.sink                 req_if,
   alars_rsp_if.source               rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);
   localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned REC_W = $bits(rec_type);

   state_type state_ff, state_in;

   logic [1:0]         mode_ff;
   logic [7:0]         spw_ff;
   logic signed [31:0] cq_ff, cc_ff, cs_ff, cl_ff;
   logic [1:0]         gain_ff [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;

   logic             op_ff, fs_ff, fw_ff, chan_ok_ff, corr_ff;
   logic [CH_W-1:0]  addr_ff;
   logic [RAW_W-1:0] raw_ff;
   logic [1:0]       gain_cur_ff;
   rec_type          rec_ff;
   logic [LUX_W-1:0] x_ff;

   logic [1:0]          lux_v_ff;
   logic [CNT_N_W-1:0]  lux_n_ff;
   logic [BASE_W-1:0]   lux_base_ff;
   logic [PROD_W-1:0]   lux_prod_ff;
   logic [CNT_Q_W-1:0]  count_scaled;
   logic [LUX_W-1:0]    lux_val;
   logic                lux_go, div_start, calc_done;

   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff, rsp_min_ff, rsp_max_ff, rsp_dsum_ff;
   logic [1:0]  rsp_gain_ff;
   logic        rsp_changed_ff, rsp_corr_ff;

   logic        accept, out_free, upd_fire, poly_start, poly_need, ram_we;
   rec_type     ram_rdata_rec, rec_cur, rec_new;
   logic [REC_W-1:0] ram_rdata;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        poly_done;
   logic [LUX_W-1:0] poly_result;
   logic [LUX_W-1:0] avg_sat;
   logic [1:0]  ns, gain_out;
   logic        auto_range, changed;
   logic [SUM_W:0] wsum_add;
   logic [LUX_W:0] dsum_add;
   logic [7:0]  divisor_n;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign avg_sat  = (div_rsp.quotient[SUM_W-1:LUX_W] != '0) ? '1
                                                             : div_rsp.quotient[LUX_W-1:0];
   assign lux_val  = LUX_W'(lux_base_ff) + LUX_W'(lux_prod_ff[PROD_W-1:RECIP_SH]);
   assign calc_done = (op_ff == OP_SAMPLE) ? lux_v_ff[1] : div_rsp.done;
   assign poly_need = (op_ff == OP_SAMPLE) && (lux_val > LUX_1000);
   assign ram_rdata_rec = rec_type'(ram_rdata);
   assign rec_cur  = valid_ff[addr_ff] ? ram_rdata_rec : '0;
   assign divisor_n = (spw_ff == '0) ? 8'd1 : spw_ff;
   assign count_scaled = CNT_Q_W'(raw_ff) << lux_shift(gain_ff[addr_ff],
                                                       mode_ff == MODE_LOW_LIGHT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_READ;
         ST_READ:   state_in = chan_ok_ff ? ST_DIV : ST_UPDATE;
         ST_DIV:    if (calc_done) state_in = poly_need ? ST_POLY : ST_UPDATE;
         ST_POLY:   if (poly_done) state_in = ST_UPDATE;
         ST_UPDATE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State decoded controls.
   always_comb begin
      req_if.ready = 1'b0;
      div_start    = 1'b0;
      lux_go       = 1'b0;
      poly_start   = 1'b0;
      upd_fire     = 1'b0;
      case (state_ff)
         ST_IDLE:   req_if.ready = 1'b1;
         ST_READ: begin
            div_start = chan_ok_ff && (op_ff == OP_CLOSE);
            lux_go    = chan_ok_ff && (op_ff == OP_SAMPLE);
         end
         ST_DIV:    poly_start   = calc_done && poly_need;
         ST_UPDATE: upd_fire     = out_free;
         default:   req_if.ready = 1'b0;
      endcase
   end

   assign ram_we = upd_fire && chan_ok_ff;

   // The divider only serves window closes; the record is read this cycle.
   always_comb begin
      div_req.start    = div_start;
      div_req.dividend = rec_cur.window_sum;
      div_req.divisor  = DEN_W'(divisor_n);
   end

   // Statistics update and result assembly.
   always_comb begin
      auto_range = (mode_ff == MODE_NORMAL) || (mode_ff == MODE_NORMAL_B);
      if (x_ff < LUX_25) begin
         ns = GAIN_DOUBLE;
      end else if (x_ff < LUX_100) begin
         ns = GAIN_UNITY;
      end else if (x_ff < LUX_10000) begin
         ns = GAIN_QUARTER;
      end else begin
         ns = GAIN_EIGHTH;
      end
      changed  = (op_ff == OP_SAMPLE) && auto_range && (ns != gain_cur_ff);
      gain_out = changed ? ns : gain_cur_ff;
      rec_new  = rec_ff;
      wsum_add = {1'b0, rec_ff.window_sum} + (SUM_W + 1)'(x_ff);
      dsum_add = {1'b0, rec_ff.display_sum} + (LUX_W + 1)'(x_ff);
      if (op_ff == OP_SAMPLE) begin
         if (fs_ff) begin
            rec_new.window_sum = SUM_W'(x_ff);
            rec_new.window_min = x_ff;
            rec_new.window_max = x_ff;
         end else begin
            rec_new.window_sum = wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];
            if (x_ff < rec_ff.window_min) rec_new.window_min = x_ff;
            if (x_ff > rec_ff.window_max) rec_new.window_max = x_ff;
         end
      end else begin
         if (fw_ff) begin
            rec_new.display_sum = x_ff;
            rec_new.display_min = rec_ff.window_min;
            rec_new.display_max = rec_ff.window_max;
         end else begin
            rec_new.display_sum = dsum_add[LUX_W] ? '1 : dsum_add[LUX_W-1:0];
            if (rec_ff.window_min < rec_ff.display_min) begin
               rec_new.display_min = rec_ff.window_min;
            end
            if (rec_ff.window_max > rec_ff.display_max) begin
               rec_new.display_max = rec_ff.window_max;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_NORMAL;
         spw_ff       <= 8'd1;
         cq_ff        <= '0;
         cc_ff        <= '0;
         cs_ff        <= '0;
         cl_ff        <= 32'sd16777216;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lux_v_ff     <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            gain_ff[i] <= GAIN_QUARTER;
         end
      end else begin
         state_ff <= state_in;
         lux_v_ff <= {lux_v_ff[0], lux_go};
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (upd_fire) begin
            rsp_valid_ff <= 1'b1;
            if (chan_ok_ff) begin
               valid_ff[addr_ff] <= 1'b1;
               gain_ff[addr_ff]  <= gain_out;
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_MODE: begin
                  mode_ff <= csr_wdata[1:0];
                  for (int i = 0; i < CHANNELS; i++) begin
                     gain_ff[i] <= (csr_wdata[1:0] == MODE_LOW_LIGHT) ? GAIN_DOUBLE
                                                                      : GAIN_QUARTER;
                  end
               end
               REG_SAMPLES:      spw_ff <= csr_wdata[7:0];
               REG_COEF_QUARTIC: cq_ff  <= $signed(csr_wdata);
               REG_COEF_CUBIC:   cc_ff  <= $signed(csr_wdata);
               REG_COEF_SQUARE:  cs_ff  <= $signed(csr_wdata);
               REG_COEF_LINEAR:  cl_ff  <= $signed(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   // Item payload and working registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_if.opcode;
         fs_ff      <= req_if.first_sample;
         fw_ff      <= req_if.first_window;
         raw_ff     <= req_if.raw_count;
         addr_ff    <= CH_W'(req_if.channel);
         chan_ok_ff <= 32'(req_if.channel) < CHANNELS;
         corr_ff    <= 1'b0;
      end
      if (state_ff == ST_READ) begin
         rec_ff      <= rec_cur;
         gain_cur_ff <= gain_ff[addr_ff];
      end
      if (lux_go) begin
         lux_n_ff    <= CNT_N_W'(count_scaled) * CNT_N_W'(LUX_MUL) + CNT_N_W'(LUX_BIAS);
         lux_base_ff <= {count_scaled, 3'b000};
      end
      if (lux_v_ff[0]) begin
         lux_prod_ff <= PROD_W'(lux_n_ff) * PROD_W'(LUX_RECIP);
      end
      if (state_ff == ST_DIV && calc_done) begin
         x_ff <= (op_ff == OP_SAMPLE) ? lux_val : avg_sat;
      end
      if (state_ff == ST_POLY && poly_done) begin
         x_ff    <= poly_result;
         corr_ff <= 1'b1;
      end
      if (upd_fire) begin
         if (chan_ok_ff) begin
            rsp_value_ff   <= x_ff;
            rsp_gain_ff    <= gain_out;
            rsp_changed_ff <= changed;
            rsp_corr_ff    <= corr_ff;
            rsp_min_ff     <= (op_ff == OP_SAMPLE) ? rec_new.window_min
                                                   : rec_new.display_min;
            rsp_max_ff     <= (op_ff == OP_SAMPLE) ? rec_new.window_max
                                                   : rec_new.display_max;
            rsp_dsum_ff    <= rec_new.display_sum;
         end else begin
            rsp_value_ff   <= '0;
            rsp_gain_ff    <= '0;
            rsp_changed_ff <= 1'b0;
            rsp_corr_ff    <= 1'b0;
            rsp_min_ff     <= '0;
            rsp_max_ff     <= '0;
            rsp_dsum_ff    <= '0;
         end
      end
   end

   alars_ram #(
      .WIDTH (REC_W),
      .DEPTH (CHANNELS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (REC_W'(rec_new)),
      .re    (accept),
      .raddr (CH_W'(req_if.channel)),
      .rdata (ram_rdata)
   );

   alars_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   alars_poly u_poly (
      .clock        (clock),
      .reset        (reset),
      .start        (poly_start),
      .x            (lux_val[XW-1:0]),
      .coef_quartic (cq_ff),
      .coef_cubic   (cc_ff),
      .coef_square  (cs_ff),
      .coef_linear  (cl_ff),
      .done         (poly_done),
      .result       (poly_result)
   );

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.value        = rsp_value_ff;
   assign rsp_if.gain_step    = rsp_gain_ff;
   assign rsp_if.gain_changed = rsp_changed_ff;
   assign rsp_if.corrected    = rsp_corr_ff;
   assign rsp_if.min_value    = rsp_min_ff;
   assign rsp_if.max_value    = rsp_max_ff;
   assign rsp_if.display_sum  = rsp_dsum_ff;

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_UPDATE)
      else $error("statistics written outside the update state");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("transfer did not start a memory read");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished while not awaited");

   a_update_result: assert property (@(posedge clock) disable iff (reset)
      upd_fire |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("update did not present a result");
endmodule
`default_nettype wire

// ===== hw/rtl/alars_ram.sv =====
`default_nettype none
module alars_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                      wdata,
   input  wire logic                                  re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/alars_div.sv =====
`default_nettype none
module alars_div
   import alars_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);
   localparam int unsigned BITS_PER_CYCLE = 2;
   localparam int unsigned ITERS = SUM_W / BITS_PER_CYCLE;
   localparam int unsigned CNT_W = $clog2(ITERS);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;

   // Restoring division: the dividend shifts out of the top of quo_ff while
   // quotient bits shift in at the bottom.
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         trial = {rem_in, quo_in[SUM_W-1]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_in[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_in[SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ITERS - 1);
            quo_ff  <= req.dividend;
            rem_ff  <= '0;
            den_ff  <= req.divisor;
         end else if (busy_ff) begin
            quo_ff <= quo_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/alars_poly.sv =====
`default_nettype none
module alars_poly
   import alars_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [XW-1:0]      x,
   input  wire logic signed [31:0] coef_quartic,
   input  wire logic signed [31:0] coef_cubic,
   input  wire logic signed [31:0] coef_square,
   input  wire logic signed [31:0] coef_linear,
   output logic                    done,
   output logic [LUX_W-1:0]        result
);
   localparam logic [1:0] PH_LO  = 2'd0;
   localparam logic [1:0] PH_HI  = 2'd1;
   localparam logic [1:0] PH_ADD = 2'd2;
   localparam int unsigned HALF = XW / 2;

   logic                busy_ff;
   logic                done_ff;
   logic [1:0]          phase_ff;
   logic [1:0]          step_ff;
   logic signed [37:0]  t_ff;
   logic [XW-1:0]       x_ff;
   logic signed [51:0]  prod_ff, prod;
   logic signed [63:0]  acc_ff, full, sum, fin;
   logic [LUX_W-1:0]    result_ff;
   logic [HALF-1:0]     mul_b;
   logic signed [31:0]  coef_sel;
   logic signed [37:0]  t_in;
   logic [LUX_W-1:0]    fin_sat;

   // Each Horner step multiplies t by X in two halves of X; the first three then shift,
   // add the next coefficient and clamp, and the last shifts and saturates the result.
   always_comb begin
      mul_b = (phase_ff == PH_LO) ? x_ff[HALF-1:0] : x_ff[XW-1:HALF];
      prod  = t_ff * $signed({1'b0, mul_b});
      full  = acc_ff + ($signed(64'(prod_ff)) <<< HALF);
      case (step_ff)
         2'd0:    coef_sel = coef_cubic;
         2'd1:    coef_sel = coef_square;
         default: coef_sel = coef_linear;
      endcase
      sum = (full >>> 20) + $signed(64'(coef_sel));
      if (sum > T_LIM) begin
         t_in = 38'(T_LIM);
      end else if (sum < -T_LIM) begin
         t_in = 38'(-T_LIM);
      end else begin
         t_in = 38'(sum);
      end
      fin = full >>> 24;
      if (fin < 0) begin
         fin_sat = '0;
      end else if (fin[63:32] != '0) begin
         fin_sat = '1;
      end else begin
         fin_sat = fin[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= PH_LO;
            step_ff  <= 2'd0;
            t_ff     <= 38'(coef_quartic);
            x_ff     <= x;
         end else if (busy_ff) begin
            case (phase_ff)
               PH_LO: begin
                  prod_ff  <= prod;
                  phase_ff <= PH_HI;
               end
               PH_HI: begin
                  acc_ff   <= $signed(64'(prod_ff));
                  prod_ff  <= prod;
                  phase_ff <= PH_ADD;
               end
               default: begin
                  if (step_ff == 2'd3) begin
                     result_ff <= fin_sat;
                     done_ff   <= 1'b1;
                     busy_ff   <= 1'b0;
                  end else begin
                     t_ff    <= t_in;
                     step_ff <= step_ff + 1'b1;
                  end
                  phase_ff <= PH_LO;
               end
            endcase
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
endmodule
`default_nettype wire
